// ===== rtl/core/bra_pkg.sv =====
// shared types and constants of the box region unit
// no dependencies; used by every other file of the block but the two interfaces
package bra_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_INTERSECT  = 2'd0,
    OP_UNION      = 2'd1,
    OP_COMPLEMENT = 2'd2
  } op_e;

  // kind of a result item
  typedef enum logic [1:0] {
    KIND_BOX   = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_UNIV  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_UXMIN = 3'd0,
    REG_UXMAX = 3'd1,
    REG_UYMIN = 3'd2,
    REG_UYMAX = 3'd3,
    REG_UOPEN = 3'd4
  } cfg_reg_e;

  // work handed from the front to the back
  typedef enum logic [2:0] {
    JOB_BOX   = 3'd0,
    JOB_EMPTY = 3'd1,
    JOB_UNIV  = 3'd2,
    JOB_PAIR  = 3'd3,
    JOB_FRAG  = 3'd4
  } job_e;

  typedef struct packed {
    job_e       job;
    logic [3:0] frag;  // complement fragments: bit0 left, bit1 right, bit2 top, bit3 bottom
  } ctl_t;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned MASK_W  = 4;

  // edges that keep the larger coordinate in an intersection (the minimums)
  localparam logic [3:0] EDGE_TAKES_MAX = 4'b0101;

  localparam logic [FIELD_W-1:0] UXMIN_RST = 32'd0;
  localparam logic [FIELD_W-1:0] UXMAX_RST = 32'd125829120;
  localparam logic [FIELD_W-1:0] UYMIN_RST = 32'd0;
  localparam logic [FIELD_W-1:0] UYMAX_RST = 32'd70778880;
  localparam logic [MASK_W-1:0]  UOPEN_RST = 4'd0;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/core/bra_in_if.sv =====
// input channel of the box region unit: valid/ready and one operation with two boxes
// depends on nothing
interface bra_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] a_xmin;
  logic signed [31:0] a_xmax;
  logic signed [31:0] a_ymin;
  logic signed [31:0] a_ymax;
  logic [3:0]        a_open_mask;
  logic signed [31:0] b_xmin;
  logic signed [31:0] b_xmax;
  logic signed [31:0] b_ymin;
  logic signed [31:0] b_ymax;
  logic [3:0]        b_open_mask;

  modport source (
    output valid, operation, a_xmin, a_xmax, a_ymin, a_ymax, a_open_mask,
           b_xmin, b_xmax, b_ymin, b_ymax, b_open_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, a_xmin, a_xmax, a_ymin, a_ymax, a_open_mask,
           b_xmin, b_xmax, b_ymin, b_ymax, b_open_mask,
    output ready
  );
endinterface

// ===== rtl/core/bra_out_if.sv =====
// result channel of the box region unit: valid/ready and one result box
// depends on nothing
interface bra_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        region_kind;
  logic signed [31:0] out_xmin;
  logic signed [31:0] out_xmax;
  logic signed [31:0] out_ymin;
  logic signed [31:0] out_ymax;
  logic [3:0]        out_open_mask;
  logic              last_of_run;

  modport source (
    output valid, region_kind, out_xmin, out_xmax, out_ymin, out_ymax, out_open_mask,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, region_kind, out_xmin, out_xmax, out_ymin, out_ymax, out_open_mask,
           last_of_run,
    output ready
  );
endinterface

// ===== rtl/core/bra_front.sv =====
// front end: accepts items, compares edges, and classifies each item into a job
// depends on bra_pkg and bra_in_if
module bra_front #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  bra_in_if.sink                                        item_i,
  input  logic [4*COORD_BITS+3:0]                       uni_i,
  input  logic                                          q_full_i,
  output logic                                          push_o,
  output logic [$bits(bra_pkg::ctl_t)+8*COORD_BITS+7:0] push_data_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned BW = 4 * CW + 4;

  logic signed [CW-1:0] av [4];
  logic signed [CW-1:0] bv [4];
  logic signed [CW-1:0] uv [4];
  logic signed [CW-1:0] sv [4];
  logic signed [CW-1:0] rv [4];
  logic [3:0]           ao, bo, uo, so, ro;
  logic [3:0]           lt, eq, gt;
  logic                 is_cmp;
  logic                 cont_as, cont_sa;
  logic [3:0]           hull_a, hull_b;
  logic [BW-1:0]        box0, box_a, box_b;
  logic                 accept;

  // stage register between edge compare and job build
  logic                 s1_valid_q, s1_valid_d;
  logic [1:0]           s1_op_q;
  logic [BW-1:0]        s1_box0_q;
  logic [BW-1:0]        s1_box1_q;
  logic                 s1_cover_q;
  logic                 s1_cont_q;
  logic [3:0]           s1_frag_q;

  logic signed [CW-1:0] rx0, rx1, ry0, ry1;
  logic                 nonempty;
  bra_pkg::ctl_t        ctl;

  assign accept      = item_i.valid && item_i.ready;
  assign item_i.ready = !s1_valid_q || !q_full_i;
  assign push_o      = s1_valid_q && !q_full_i;

  always_comb begin
    av[0] = CW'({32'b0, item_i.a_xmin});
    av[1] = CW'({32'b0, item_i.a_xmax});
    av[2] = CW'({32'b0, item_i.a_ymin});
    av[3] = CW'({32'b0, item_i.a_ymax});
    bv[0] = CW'({32'b0, item_i.b_xmin});
    bv[1] = CW'({32'b0, item_i.b_xmax});
    bv[2] = CW'({32'b0, item_i.b_ymin});
    bv[3] = CW'({32'b0, item_i.b_ymax});
    ao    = item_i.a_open_mask;
    bo    = item_i.b_open_mask;
    uv[0] = uni_i[BW-1 -: CW];
    uv[1] = uni_i[BW-1-CW -: CW];
    uv[2] = uni_i[BW-1-2*CW -: CW];
    uv[3] = uni_i[CW+3 -: CW];
    uo    = uni_i[3:0];
    is_cmp = (item_i.operation == bra_pkg::OP_COMPLEMENT);
    // complement clips a against the universe, otherwise a meets b
    for (int e = 0; e < 4; e++) begin
      sv[e] = is_cmp ? uv[e] : bv[e];
    end
    so = is_cmp ? uo : bo;
    for (int e = 0; e < 4; e++) begin
      lt[e] = av[e] < sv[e];
      eq[e] = av[e] == sv[e];
      gt[e] = !lt[e] && !eq[e];
      if (eq[e]) begin
        rv[e] = av[e];
        ro[e] = ao[e] | so[e];
      end else if (bra_pkg::EDGE_TAKES_MAX[e] ? gt[e] : lt[e]) begin
        rv[e] = av[e];
        ro[e] = ao[e];
      end else begin
        rv[e] = sv[e];
        ro[e] = so[e];
      end
    end
    // a contains s; for a complement this is the covering test
    cont_as = !gt[0] && !lt[1] && !gt[2] && !lt[3];
    cont_sa = !lt[0] && !gt[1] && !lt[2] && !gt[3];
    hull_a  = (ao & ~eq) | (ao & bo & eq);
    hull_b  = (bo & ~eq) | (ao & bo & eq);
    box_a   = {av[0], av[1], av[2], av[3], ao};
    box_b   = {bv[0], bv[1], bv[2], bv[3], bo};
    case (item_i.operation)
      bra_pkg::OP_UNION: begin
        if (cont_as) begin
          box0 = {av[0], av[1], av[2], av[3], hull_a};
        end else if (cont_sa) begin
          box0 = {bv[0], bv[1], bv[2], bv[3], hull_b};
        end else begin
          box0 = box_a;
        end
      end
      default: begin
        box0 = {rv[0], rv[1], rv[2], rv[3], ro};
      end
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= item_i.operation;
      s1_box0_q  <= box0;
      s1_box1_q  <= box_b;
      s1_cover_q <= cont_as;
      s1_cont_q  <= cont_as || cont_sa;
      s1_frag_q  <= {lt[3] | ro[3], gt[2] | ro[2], lt[1] | ro[1], gt[0] | ro[0]};
    end
  end

  // job build from the registered compare results
  assign rx0 = s1_box0_q[BW-1 -: CW];
  assign rx1 = s1_box0_q[BW-1-CW -: CW];
  assign ry0 = s1_box0_q[BW-1-2*CW -: CW];
  assign ry1 = s1_box0_q[CW+3 -: CW];
  assign nonempty = (rx0 < rx1) && (ry0 < ry1);

  always_comb begin
    ctl.frag = s1_frag_q;
    case (s1_op_q)
      bra_pkg::OP_INTERSECT: begin
        ctl.job = nonempty ? bra_pkg::JOB_BOX : bra_pkg::JOB_EMPTY;
      end
      bra_pkg::OP_UNION: begin
        ctl.job = s1_cont_q ? bra_pkg::JOB_BOX : bra_pkg::JOB_PAIR;
      end
      bra_pkg::OP_COMPLEMENT: begin
        if (s1_cover_q) begin
          ctl.job = bra_pkg::JOB_EMPTY;
        end else if (!nonempty) begin
          ctl.job = bra_pkg::JOB_UNIV;
        end else if (s1_frag_q == 4'b0000) begin
          ctl.job = bra_pkg::JOB_EMPTY;
        end else begin
          ctl.job = bra_pkg::JOB_FRAG;
        end
      end
      default: begin
        ctl.job = bra_pkg::JOB_EMPTY;
      end
    endcase
  end

  assign push_data_o = {ctl, s1_box0_q, s1_box1_q};

endmodule

// ===== rtl/core/bra_queue.sv =====
// short job queue between front and back, four entries of flip-flops
// depends on bra_pkg for its depth
module bra_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0]                  mem_q [bra_pkg::QUEUE_DEPTH];
  logic [bra_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [bra_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [bra_pkg::QCNT_W-1:0]        count_q, count_d;

  assign full_o  = (count_q == bra_pkg::QCNT_W'(bra_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == bra_pkg::QPTR_W'(bra_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == bra_pkg::QPTR_W'(bra_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/bra_back.sv =====
// back end: walks each queued job and sends its result boxes, one a cycle while the result port is ready
// depends on bra_pkg and bra_out_if
module bra_back #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          head_valid_i,
  input  logic [$bits(bra_pkg::ctl_t)+8*COORD_BITS+7:0] head_i,
  input  logic [4*COORD_BITS+3:0]                       uni_i,
  output logic                                          pop_o,
  bra_out_if.source                                     result_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned BW = 4 * CW + 4;

  bra_pkg::ctl_t        ctl;
  logic [BW-1:0]        box0, box1;
  logic signed [CW-1:0] cx0, cx1, cy0, cy1;
  logic signed [CW-1:0] ux0, ux1, uy0, uy1;
  logic [3:0]           co;
  logic [3:0]           pending, sel;

  // fragments or pair half already sent for the job at the head
  logic [3:0]           step_q, step_d;
  logic [3:0]           mark;

  bra_pkg::kind_e       kind;
  logic signed [CW-1:0] rx0, rx1, ry0, ry1;
  logic [3:0]           ro;
  logic                 last;
  logic                 adv;

  logic                 out_valid_q, out_valid_d;
  bra_pkg::kind_e       kind_q;
  logic [31:0]          xmin_q, xmax_q, ymin_q, ymax_q;
  logic [3:0]           open_q;
  logic                 last_q;

  function automatic logic [31:0] to_field(input logic signed [CW-1:0] c);
    logic signed [63:0] wide;
    wide = 64'(c);
    return wide[31:0];
  endfunction

  assign {ctl, box0, box1} = head_i;
  assign cx0 = box0[BW-1 -: CW];
  assign cx1 = box0[BW-1-CW -: CW];
  assign cy0 = box0[BW-1-2*CW -: CW];
  assign cy1 = box0[CW+3 -: CW];
  assign co  = box0[3:0];
  assign ux0 = uni_i[BW-1 -: CW];
  assign ux1 = uni_i[BW-1-CW -: CW];
  assign uy0 = uni_i[BW-1-2*CW -: CW];
  assign uy1 = uni_i[CW+3 -: CW];

  assign pending = ctl.frag & ~step_q;
  assign sel     = pending & (~pending + 4'd1);

  assign adv   = head_valid_i && (!out_valid_q || result_o.ready);
  assign pop_o = adv && last;

  always_comb begin
    kind = bra_pkg::KIND_EMPTY;
    rx0  = '0;
    rx1  = '0;
    ry0  = '0;
    ry1  = '0;
    ro   = '0;
    last = 1'b1;
    mark = '0;
    case (ctl.job)
      bra_pkg::JOB_BOX: begin
        kind = bra_pkg::KIND_BOX;
        {rx0, rx1, ry0, ry1, ro} = box0;
      end
      bra_pkg::JOB_EMPTY: begin
        kind = bra_pkg::KIND_EMPTY;
      end
      bra_pkg::JOB_UNIV: begin
        kind = bra_pkg::KIND_UNIV;
      end
      bra_pkg::JOB_PAIR: begin
        kind = bra_pkg::KIND_BOX;
        if (!step_q[0]) begin
          {rx0, rx1, ry0, ry1, ro} = box0;
          last = 1'b0;
          mark = 4'b0001;
        end else begin
          {rx0, rx1, ry0, ry1, ro} = box1;
        end
      end
      bra_pkg::JOB_FRAG: begin
        kind = bra_pkg::KIND_BOX;
        last = ((pending & ~sel) == 4'b0000);
        mark = sel;
        // fragment order left, right, top, bottom; universe edges come out closed
        if (sel[0]) begin
          rx0 = ux0;
          rx1 = cx0;
          ry0 = cy0;
          ry1 = cy1;
          ro  = {co[3], co[2], ~co[0], 1'b0};
        end else if (sel[1]) begin
          rx0 = cx1;
          rx1 = ux1;
          ry0 = cy0;
          ry1 = cy1;
          ro  = {co[3], co[2], 1'b0, ~co[1]};
        end else if (sel[2]) begin
          rx0 = ux0;
          rx1 = ux1;
          ry0 = uy0;
          ry1 = cy0;
          ro  = {~co[2], 3'b000};
        end else begin
          rx0 = ux0;
          rx1 = ux1;
          ry0 = cy1;
          ry1 = uy1;
          ro  = {1'b0, ~co[3], 2'b00};
        end
      end
      default: begin
        kind = bra_pkg::KIND_EMPTY;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (adv) begin
      step_d = last ? 4'b0000 : (step_q | mark);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q <= kind;
      xmin_q <= to_field(rx0);
      xmax_q <= to_field(rx1);
      ymin_q <= to_field(ry0);
      ymax_q <= to_field(ry1);
      open_q <= ro;
      last_q <= last;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.region_kind   = kind_q;
  assign result_o.out_xmin      = xmin_q;
  assign result_o.out_xmax      = xmax_q;
  assign result_o.out_ymin      = ymin_q;
  assign result_o.out_ymax      = ymax_q;
  assign result_o.out_open_mask = open_q;
  assign result_o.last_of_run   = last_q;

endmodule

// ===== rtl/core/box_region_algebra.sv =====
// Axis-aligned box unit: intersection, union and complement within a configured universe,
// Q16.16 coordinates. An item can be accepted every cycle unless the front is held by a full
// job queue; results leave one a cycle while the result port is ready. An item gives one
// result for an intersection, one or two for a union, one to four for a complement. The result
// register is the limit. A result passes through the compare register, the job queue and the
// result register; a four-entry job queue lets the front keep accepting while the back is still
// sending fragments. The user must write the universe registers only while the unit is idle;
// the unit itself does not enforce this.
// depends on bra_pkg, bra_in_if, bra_out_if, bra_front, bra_queue and bra_back
module box_region_algebra #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  bra_in_if.sink      item_i,
  bra_out_if.source   result_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned BW  = 4 * CW + 4;
  localparam int unsigned QW  = $bits(bra_pkg::ctl_t) + 2 * BW;

  logic [31:0]   uxmin_q, uxmax_q, uymin_q, uymax_q;
  logic [3:0]    uopen_q;
  logic [BW-1:0] uni_box;

  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uxmin_q <= bra_pkg::UXMIN_RST;
      uxmax_q <= bra_pkg::UXMAX_RST;
      uymin_q <= bra_pkg::UYMIN_RST;
      uymax_q <= bra_pkg::UYMAX_RST;
      uopen_q <= bra_pkg::UOPEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bra_pkg::REG_UXMIN: uxmin_q <= cfg_data_i;
        bra_pkg::REG_UXMAX: uxmax_q <= cfg_data_i;
        bra_pkg::REG_UYMIN: uymin_q <= cfg_data_i;
        bra_pkg::REG_UYMAX: uymax_q <= cfg_data_i;
        bra_pkg::REG_UOPEN: uopen_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // universe at coordinate width: low bits, or zero-extended past the field
  assign uni_box = {CW'({32'b0, uxmin_q}), CW'({32'b0, uxmax_q}),
                    CW'({32'b0, uymin_q}), CW'({32'b0, uymax_q}), uopen_q};

  bra_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .uni_i       (uni_box),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bra_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  bra_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .uni_i        (uni_box),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule

// ===== tb/box_region_algebra_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of box_region_algebra: directed and random box operations
// depends on bra_pkg, bra_in_if, bra_out_if and the box_region_algebra rtl
module box_region_algebra_tb;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [31:0] COORD_MIN     = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX     = 32'h7FFF_FFFF;
  localparam int          IDLE_LIMIT    = 2000;
  localparam int          LATENCY_SLACK = 8;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic [3:0]         open_mask;
  } box_t;

  typedef struct packed {
    logic [1:0] op;
    box_t       a;
    box_t       b;
  } op_item_t;

  typedef struct packed {
    bra_pkg::kind_e kind;
    box_t           bx;
    logic           last;
  } region_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  bra_in_if  item_if ();
  bra_out_if result_if ();

  box_region_algebra i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  op_item_t    op_queue[$];
  region_t     region_queue[$];
  op_item_t    cur_item;
  box_t        universe;
  int          mismatches;
  int          gap_left;
  int          beats_to_gap;
  logic [15:0] stall_pattern;
  int          stall_pos;
  int          idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_region(input bra_pkg::kind_e kind, input box_t bx,
                                      input bit last);
    region_t e;
    e.kind = kind;
    e.bx   = (kind == bra_pkg::KIND_BOX) ? bx : '0;
    e.last = last;
    region_queue = {region_queue, e};
  endfunction

  // ties keep the coordinate and open the edge if either side is open
  function automatic void merge_edge(input logic signed [31:0] p, input logic signed [31:0] q,
                                     input logic po, input logic qo, input bit take_max,
                                     output logic signed [31:0] v, output logic o);
    if (p == q) begin
      v = p;
      o = po | qo;
    end else if ((p > q) == take_max) begin
      v = p;
      o = po;
    end else begin
      v = q;
      o = qo;
    end
  endfunction

  function automatic bit clip_box(input box_t a, input box_t b, output box_t r);
    merge_edge(a.x0, b.x0, a.open_mask[0], b.open_mask[0], 1'b1, r.x0, r.open_mask[0]);
    merge_edge(a.x1, b.x1, a.open_mask[1], b.open_mask[1], 1'b0, r.x1, r.open_mask[1]);
    merge_edge(a.y0, b.y0, a.open_mask[2], b.open_mask[2], 1'b1, r.y0, r.open_mask[2]);
    merge_edge(a.y1, b.y1, a.open_mask[3], b.open_mask[3], 1'b0, r.y1, r.open_mask[3]);
    return $signed(r.x0) < $signed(r.x1) && $signed(r.y0) < $signed(r.y1);
  endfunction

  function automatic bit encloses(input box_t o, input box_t i);
    return $signed(o.x0) <= $signed(i.x0) && $signed(i.x1) <= $signed(o.x1) &&
           $signed(o.y0) <= $signed(i.y0) && $signed(i.y1) <= $signed(o.y1);
  endfunction

  // outer box kept; a shared edge stays open only if both are open
  function automatic box_t merge_hull(input box_t o, input box_t i);
    box_t       r;
    logic [3:0] eq;
    eq = {o.y1 == i.y1, o.y0 == i.y0, o.x1 == i.x1, o.x0 == i.x0};
    r = o;
    r.open_mask = (o.open_mask & ~eq) | (o.open_mask & i.open_mask & eq);
    return r;
  endfunction

  function automatic void predict_regions(input op_item_t it);
    box_t r;
    box_t c;
    box_t frag [4];
    int   n;
    int   k;
    n = 0;
    case (it.op)
      bra_pkg::OP_INTERSECT: begin
        if (clip_box(it.a, it.b, r)) push_region(bra_pkg::KIND_BOX, r, 1'b1);
        else push_region(bra_pkg::KIND_EMPTY, '0, 1'b1);
      end
      bra_pkg::OP_UNION: begin
        if (encloses(it.a, it.b)) begin
          push_region(bra_pkg::KIND_BOX, merge_hull(it.a, it.b), 1'b1);
        end else if (encloses(it.b, it.a)) begin
          push_region(bra_pkg::KIND_BOX, merge_hull(it.b, it.a), 1'b1);
        end else begin
          push_region(bra_pkg::KIND_BOX, it.a, 1'b0);
          push_region(bra_pkg::KIND_BOX, it.b, 1'b1);
        end
      end
      bra_pkg::OP_COMPLEMENT: begin
        if (encloses(it.a, universe)) begin
          push_region(bra_pkg::KIND_EMPTY, '0, 1'b1);
        end else if (!clip_box(it.a, universe, c)) begin
          push_region(bra_pkg::KIND_UNIV, '0, 1'b1);
        end else begin
          // fragment edges on the universe boundary are always closed
          if ($signed(c.x0) > $signed(universe.x0) ||
              (c.x0 == universe.x0 && c.open_mask[0])) begin
            frag[n] = c;
            frag[n].x0 = universe.x0;
            frag[n].x1 = c.x0;
            frag[n].open_mask = {c.open_mask[3:2], !c.open_mask[0], 1'b0};
            n++;
          end
          if ($signed(c.x1) < $signed(universe.x1) ||
              (c.x1 == universe.x1 && c.open_mask[1])) begin
            frag[n] = c;
            frag[n].x0 = c.x1;
            frag[n].x1 = universe.x1;
            frag[n].open_mask = {c.open_mask[3:2], 1'b0, !c.open_mask[1]};
            n++;
          end
          if ($signed(c.y0) > $signed(universe.y0) ||
              (c.y0 == universe.y0 && c.open_mask[2])) begin
            frag[n] = universe;
            frag[n].y1 = c.y0;
            frag[n].open_mask = {!c.open_mask[2], 3'b000};
            n++;
          end
          if ($signed(c.y1) < $signed(universe.y1) ||
              (c.y1 == universe.y1 && c.open_mask[3])) begin
            frag[n] = universe;
            frag[n].y0 = c.y1;
            frag[n].open_mask = {1'b0, !c.open_mask[3], 2'b00};
            n++;
          end
          if (n == 0) push_region(bra_pkg::KIND_EMPTY, '0, 1'b1);
          for (k = 0; k < n; k++) push_region(bra_pkg::KIND_BOX, frag[k], k == n - 1);
        end
      end
      default: push_region(bra_pkg::KIND_EMPTY, '0, 1'b1);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [31:0] q16(input int v);
    return v * 65536;
  endfunction

  function automatic box_t mk_box(input logic [31:0] x0, input logic [31:0] x1,
                                  input logic [31:0] y0, input logic [31:0] y1,
                                  input logic [3:0] m);
    box_t r;
    r.x0 = x0;
    r.x1 = x1;
    r.y0 = y0;
    r.y1 = y1;
    r.open_mask = m;
    return r;
  endfunction

  function automatic void add_op(input logic [1:0] op, input box_t a, input box_t b);
    op_item_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    op_queue = {op_queue, it};
  endfunction

  // mostly near the span edges or on a coarse grid across it, so ties are frequent
  function automatic logic [31:0] pick_coord(input longint lo, input longint hi);
    longint v;
    case ($urandom_range(0, 11))
      0: v = lo;
      1: v = hi;
      2: v = lo + longint'($urandom_range(0, 2)) - 1;
      3: v = hi + longint'($urandom_range(0, 2)) - 1;
      4: v = longint'($signed(COORD_MIN));
      5: v = longint'($signed(COORD_MAX));
      6: v = longint'($signed($urandom));
      default: v = lo + ((hi - lo) / 16) * (longint'($urandom_range(0, 18)) - 1);
    endcase
    return v[31:0];
  endfunction

  function automatic box_t random_box();
    box_t        r;
    logic [31:0] p;
    logic [31:0] q;
    longint      lx, hx, ly, hy;
    lx = longint'($signed(universe.x0));
    hx = longint'($signed(universe.x1));
    ly = longint'($signed(universe.y0));
    hy = longint'($signed(universe.y1));
    p = pick_coord(lx, hx);
    q = pick_coord(lx, hx);
    if ($urandom_range(0, 9) != 0 && $signed(p) > $signed(q)) {p, q} = {q, p};
    r.x0 = p;
    r.x1 = q;
    p = pick_coord(ly, hy);
    q = pick_coord(ly, hy);
    if ($urandom_range(0, 9) != 0 && $signed(p) > $signed(q)) {p, q} = {q, p};
    r.y0 = p;
    r.y1 = q;
    r.open_mask = 4'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic logic [31:0] shift_edge(input logic [31:0] e, input longint step);
    longint v;
    case ($urandom_range(0, 3))
      2: v = longint'($signed(e)) + step;
      3: v = longint'($signed(e)) - step;
      default: v = longint'($signed(e));
    endcase
    return v[31:0];
  endfunction

  // box sharing or nesting with a, to reach containment and equal edges
  function automatic box_t nested_box(input box_t a);
    box_t   r;
    longint wx, wy;
    wx = (longint'($signed(a.x1)) - longint'($signed(a.x0))) / 4;
    wy = (longint'($signed(a.y1)) - longint'($signed(a.y0))) / 4;
    r.x0 = shift_edge(a.x0, wx);
    r.x1 = shift_edge(a.x1, -wx);
    r.y0 = shift_edge(a.y0, wy);
    r.y1 = shift_edge(a.y1, -wy);
    r.open_mask = 4'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic add_random_ops(input int count);
    int         sel;
    logic [1:0] op;
    box_t       a;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) op = OP_UNUSED;
      else if (sel < 34) op = bra_pkg::OP_INTERSECT;
      else if (sel < 67) op = bra_pkg::OP_UNION;
      else op = bra_pkg::OP_COMPLEMENT;
      a = random_box();
      add_op(op, a, ($urandom_range(0, 1) != 0) ? nested_box(a) : random_box());
    end
  endtask

  task automatic write_reg(input bra_pkg::cfg_reg_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic set_universe(input logic [31:0] x0, input logic [31:0] x1,
                              input logic [31:0] y0, input logic [31:0] y1,
                              input logic [3:0] m);
    write_reg(bra_pkg::REG_UXMIN, x0);
    write_reg(bra_pkg::REG_UXMAX, x1);
    write_reg(bra_pkg::REG_UYMIN, y0);
    write_reg(bra_pkg::REG_UYMAX, y1);
    write_reg(bra_pkg::REG_UOPEN, {28'd0, m});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    universe = mk_box(x0, x1, y0, y1, m);
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (op_queue.size() != 0 || item_if.valid || region_queue.size() != 0);
    repeat (LATENCY_SLACK) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin : driver
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      gap_left = 0;
      beats_to_gap = 1;
    end else begin
      if (item_if.valid && item_if.ready) predict_regions(cur_item);
      if (!item_if.valid || item_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_if.valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          cur_item = op_queue.pop_front();
          item_if.valid       <= 1'b1;
          item_if.operation   <= cur_item.op;
          item_if.a_xmin      <= cur_item.a.x0;
          item_if.a_xmax      <= cur_item.a.x1;
          item_if.a_ymin      <= cur_item.a.y0;
          item_if.a_ymax      <= cur_item.a.y1;
          item_if.a_open_mask <= cur_item.a.open_mask;
          item_if.b_xmin      <= cur_item.b.x0;
          item_if.b_xmax      <= cur_item.b.x1;
          item_if.b_ymin      <= cur_item.b.y0;
          item_if.b_ymax      <= cur_item.b.y1;
          item_if.b_open_mask <= cur_item.b.open_mask;
          beats_to_gap--;
          if (beats_to_gap == 0) begin
            beats_to_gap = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    region_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_pattern = '1;
      stall_pos = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (region_queue.size() == 0) begin
          $error("result beat with no pending expectation");
          mismatches++;
        end else begin
          want = region_queue.pop_front();
          check_field("region_kind", 32'(want.kind), 32'(result_if.region_kind));
          check_field("out_xmin", want.bx.x0, result_if.out_xmin);
          check_field("out_xmax", want.bx.x1, result_if.out_xmax);
          check_field("out_ymin", want.bx.y0, result_if.out_ymin);
          check_field("out_ymax", want.bx.y1, result_if.out_ymax);
          check_field("out_open_mask", 32'(want.bx.open_mask), 32'(result_if.out_open_mask));
          check_field("last_of_run", 32'(want.last), 32'(result_if.last_of_run));
        end
      end
      result_if.ready <= stall_pattern[stall_pos];
      stall_pos++;
      if (stall_pos == 16) begin
        stall_pos = 0;
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom & $urandom & $urandom);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [31:0] p, q, s, t;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bra_pkg::REG_UXMIN;
    cfg_data_i = '0;
    item_if.valid = 1'b0;
    item_if.operation = bra_pkg::OP_INTERSECT;
    item_if.a_xmin = '0;
    item_if.a_xmax = '0;
    item_if.a_ymin = '0;
    item_if.a_ymax = '0;
    item_if.a_open_mask = '0;
    item_if.b_xmin = '0;
    item_if.b_xmax = '0;
    item_if.b_ymin = '0;
    item_if.b_ymax = '0;
    item_if.b_open_mask = '0;
    result_if.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    universe = mk_box(bra_pkg::UXMIN_RST, bra_pkg::UXMAX_RST, bra_pkg::UYMIN_RST,
                      bra_pkg::UYMAX_RST, bra_pkg::UOPEN_RST);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset universe 1920 x 1080, closed edges
    add_op(bra_pkg::OP_INTERSECT, mk_box(0, q16(100), 0, q16(100), 4'b0101),
           mk_box(0, q16(100), q16(50), q16(150), 4'b1010));
    add_op(bra_pkg::OP_INTERSECT, mk_box(0, q16(10), 0, q16(10), 4'b0000),
           mk_box(q16(20), q16(30), 0, q16(10), 4'b1111));
    add_op(bra_pkg::OP_INTERSECT, mk_box(0, q16(10), 0, q16(10), 4'b0011),
           mk_box(q16(10), q16(20), 0, q16(10), 4'b1100));
    add_op(bra_pkg::OP_INTERSECT,
           mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b1111),
           mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b0000));
    add_op(bra_pkg::OP_INTERSECT,
           mk_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 4'b0110),
           mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b1001));
    add_op(bra_pkg::OP_UNION, mk_box(0, q16(100), 0, q16(100), 4'b1111),
           mk_box(0, q16(50), q16(10), q16(100), 4'b0011));
    add_op(bra_pkg::OP_UNION, mk_box(q16(10), q16(20), q16(10), q16(20), 4'b0101),
           mk_box(0, q16(100), 0, q16(100), 4'b1010));
    add_op(bra_pkg::OP_UNION, mk_box(0, q16(10), 0, q16(10), 4'b0001),
           mk_box(q16(50), q16(60), q16(-20), q16(-10), 4'b1000));
    add_op(bra_pkg::OP_UNION, mk_box(q16(-5), q16(5), q16(-5), q16(5), 4'b1100),
           mk_box(q16(-5), q16(5), q16(-5), q16(5), 4'b0110));
    add_op(bra_pkg::OP_UNION, mk_box(0, q16(100), 0, q16(100), 4'b0000),
           mk_box(q16(50), q16(150), q16(50), q16(150), 4'b1111));
    add_op(bra_pkg::OP_UNION, mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b1111),
           mk_box(COORD_MIN, q16(1), q16(-1), COORD_MAX, 4'b1111));
    // complement: covering, exact universe, disjoint, inside, open edge on the boundary
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(q16(-10), q16(2000), q16(-10), q16(1100), 4'b1111), random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(0, q16(1920), 0, q16(1080), 4'b1111),
           random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(q16(-100), q16(-50), 0, q16(100), 4'b0000),
           random_box());
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(q16(100), q16(200), q16(300), q16(400), 4'b0110), random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(0, q16(500), 0, q16(1080), 4'b0001),
           random_box());
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(q16(100), q16(3000), q16(200), q16(2000), 4'b0000), random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(q16(300), q16(100), 0, q16(50), 4'b0000),
           random_box());
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b0000), random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(q16(1920), q16(2000), 0, q16(100), 4'b0000),
           random_box());
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(q16(10), q16(1920), q16(5), q16(1080), 4'b1010), random_box());
    add_op(OP_UNUSED, random_box(), random_box());
    add_random_ops(90);
    wait_idle();

    // widest universe, all edges open: clipping picks up the universe openness
    set_universe(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b1111);
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 4'b0000), random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(COORD_MIN, 0, COORD_MIN, 0, 4'b0000),
           random_box());
    add_op(bra_pkg::OP_COMPLEMENT, mk_box(0, COORD_MAX, 0, q16(10), 4'b0000), random_box());
    add_random_ops(60);
    wait_idle();

    set_universe(q16(-500), q16(300), q16(-200), q16(900) + 7, 4'b0101);
    add_random_ops(50);
    wait_idle();

    // inverted universe: complements yield the whole universe unless a covers it
    set_universe(q16(400), q16(100), q16(50), q16(60), 4'b0000);
    add_op(bra_pkg::OP_COMPLEMENT,
           mk_box(q16(100), q16(200), q16(100), q16(200), 4'b0000), random_box());
    add_random_ops(30);
    wait_idle();

    p = $urandom;
    q = $urandom;
    s = $urandom;
    t = $urandom;
    if ($signed(p) > $signed(q)) {p, q} = {q, p};
    if ($signed(s) > $signed(t)) {s, t} = {t, s};
    set_universe(p, q, s, t, 4'($urandom_range(0, 15)));
    add_random_ops(56);
    wait_idle();

    if (mismatches == 0 && region_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
